FILE: hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared widths, operation and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned PriW     = 16;
  localparam int unsigned ValW     = 16;
  localparam int unsigned StatW    = 2;
  localparam int unsigned OccW     = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic accept;
    logic load_tail;
    logic load_zero;
    logic dec;
    logic we;
    logic wr_new;
    logic wr_at_idx;
    logic take_head;
    logic inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic req_deq;
    logic full;
    logic empty;
    logic ge;
    logic idx_zero;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded sorted queue; highest priority leaves first, ties leave in order.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries one word: operation_i
// (enqueue or dequeue), priority_req_i and value_i. Output channel
// (out_valid_o / out_stall_i) returns one word per input word: result_value_o,
// status_o (ok, dequeue on empty, enqueue dropped on full) and occupancy_o.
// Entries sit in a circular memory with a head pointer. A dequeue reads the
// head entry and then registers its value as the result; a dequeue on empty
// or an enqueue dropped on full registers its status directly. An
// enqueue scans from the tail toward the head one entry per cycle through the
// single memory read port, moving each lower-priority entry back one slot,
// then writes the new entry behind the last entry of equal or higher
// priority (at the head slot on empty).
// One word is in flight at a time; the next input is accepted on the cycle
// after the result is registered, even while that result is still stalled.
// If the receiver stalls, the result holds and a finished word waits in the
// controller until the output register frees up.
// Reset empties the queue at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              operation_i,
  input  logic signed [spq_pkg::PriW-1:0]   priority_req_i,
  input  logic signed [spq_pkg::ValW-1:0]   value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [spq_pkg::ValW-1:0]   result_value_o,
  output logic [spq_pkg::StatW-1:0]         status_o,
  output logic [spq_pkg::OccW-1:0]          occupancy_o
);
  import spq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operation_i    (operation_i),
    .priority_req_i (priority_req_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o),
    .cmd_i          (cmd),
    .st_o           (st)
  );

endmodule

FILE: hdl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// Stable priority queue controller
// Sequences accept, insertion scan, head removal and result hand-off.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::stat_t st_i,
  output spq_pkg::cmd_t  cmd_o
);
  import spq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_PUT  = 3'd2;
  localparam logic [2:0] S_DEQ  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (st_i.req_deq) begin
            if (st_i.empty) begin
              state_d = S_FIN;
            end else begin
              cmd_o.load_zero = 1'b1;
              state_d         = S_DEQ;
            end
          end else if (st_i.full) begin
            state_d = S_FIN;
          end else if (st_i.empty) begin
            cmd_o.load_zero = 1'b1;
            state_d         = S_PUT;
          end else begin
            cmd_o.load_tail = 1'b1;
            state_d         = S_CMP;
          end
        end
      end
      S_CMP: begin
        cmd_o.we = 1'b1;
        if (st_i.ge) begin
          cmd_o.wr_new = 1'b1;
          cmd_o.inc    = 1'b1;
          state_d      = S_FIN;
        end else if (st_i.idx_zero) begin
          state_d = S_PUT;
        end else begin
          cmd_o.dec = 1'b1;
        end
      end
      S_PUT: begin
        cmd_o.we        = 1'b1;
        cmd_o.wr_new    = 1'b1;
        cmd_o.wr_at_idx = 1'b1;
        cmd_o.inc       = 1'b1;
        state_d         = S_FIN;
      end
      S_DEQ: begin
        cmd_o.take_head = 1'b1;
        state_d         = S_FIN;
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_cmp_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> !st_i.full)
    else $error("insertion scan on a full store");

  a_deq_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEQ) |-> !st_i.empty)
    else $error("head removal on an empty store");

endmodule

FILE: hdl/spq_dp.sv
// ----------------------------------------------------------------------------
// Stable priority queue datapath
// Circular entry memory, head pointer, count, scan cursor and result register.
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int unsigned DEPTH = spq_pkg::DepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              operation_i,
  input  logic signed [spq_pkg::PriW-1:0]   priority_req_i,
  input  logic signed [spq_pkg::ValW-1:0]   value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [spq_pkg::ValW-1:0]   result_value_o,
  output logic [spq_pkg::StatW-1:0]         status_o,
  output logic [spq_pkg::OccW-1:0]          occupancy_o,
  input  spq_pkg::cmd_t                     cmd_i,
  output spq_pkg::stat_t                    st_o
);
  import spq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = PriW + ValW;
  localparam logic [AW:0] DepthA = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata_q;

  logic [AW-1:0] head_q, idx_q, idx_d;
  logic [CW-1:0] count_q;
  logic signed [PriW-1:0] pri_q;
  logic signed [ValW-1:0] val_q;
  logic signed [ValW-1:0] res_q;
  logic [StatW-1:0]       stat_q;

  logic                   ov_q;
  logic signed [ValW-1:0] ores_q;
  logic [StatW-1:0]       ostat_q;
  logic [OccW-1:0]        oocc_q;

  logic [AW-1:0] raddr, waddr, tail, idx_inc, head_inc;
  logic [WW-1:0] wdata;
  logic [CW-1:0] count_dec;
  logic [CW+OccW-1:0] count_ext;
  logic full, empty;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, head} + {1'b0, l};
    if (s >= DepthA) begin
      s = s - DepthA;
    end
    return s[AW-1:0];
  endfunction

  assign full      = (count_q == DepthC);
  assign empty     = (count_q == '0);
  assign count_dec = count_q - 1'b1;
  assign tail      = count_dec[AW-1:0];
  assign idx_inc   = idx_q + 1'b1;
  assign head_inc  = ({1'b0, head_q} == DepthA - 1'b1) ? '0 : head_q + 1'b1;
  assign count_ext = {{OccW{1'b0}}, count_q};

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load_tail) begin
      idx_d = tail;
    end else if (cmd_i.load_zero) begin
      idx_d = '0;
    end else if (cmd_i.dec) begin
      idx_d = idx_q - 1'b1;
    end
  end

  assign raddr = phys(head_q, idx_d);
  assign waddr = cmd_i.wr_at_idx ? phys(head_q, idx_q) : phys(head_q, idx_inc);
  assign wdata = cmd_i.wr_new ? {pri_q, val_q} : rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.accept) begin
      pri_q <= priority_req_i;
      val_q <= value_i;
      res_q <= '0;
      if (operation_i == OP_ENQ && full) begin
        stat_q <= ST_FULL;
      end else if (operation_i == OP_DEQ && empty) begin
        stat_q <= ST_EMPTY;
      end else begin
        stat_q <= ST_OK;
      end
    end else if (cmd_i.take_head) begin
      res_q <= rdata_q[ValW-1:0];
    end
    if (cmd_i.out_load) begin
      ores_q  <= res_q;
      ostat_q <= stat_q;
      oocc_q  <= count_ext[OccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (cmd_i.take_head) begin
        head_q  <= head_inc;
        count_q <= count_dec;
      end else if (cmd_i.inc) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign st_o.req_deq  = (operation_i == OP_DEQ);
  assign st_o.full     = full;
  assign st_o.empty    = empty;
  assign st_o.ge       = ($signed(rdata_q[WW-1:ValW]) >= pri_q);
  assign st_o.idx_zero = (idx_q == '0);
  assign st_o.out_free = !ov_q || !out_stall_i;

  assign out_valid_o    = ov_q;
  assign result_value_o = ores_q;
  assign status_o       = ostat_q;
  assign occupancy_o    = oocc_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count above depth");

  a_take_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_head |=> count_q == $past(count_dec))
    else $error("head removal did not drop the count");

  a_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.we |-> !full)
    else $error("entry write into a full store");

endmodule
